[rtl/hpss_pkg.sv]
// Package with types, constants and the sine and weight tables of the plucked-string synth.
`default_nettype none
package hpss_pkg;

    localparam int MaxPeriod      = 2048;
    localparam int HarmonicCount  = 26;
    localparam int SineDepth      = 1024;
    localparam int AddrW          = $clog2(MaxPeriod);
    localparam int SineW          = $clog2(SineDepth);
    localparam int HarmW          = $clog2(HarmonicCount);
    localparam int RingW          = 24;

    localparam logic [1:0] RegPeriod    = 2'd0;
    localparam logic [1:0] RegPhaseStep = 2'd1;
    localparam logic [1:0] RegDampGain  = 2'd2;

    localparam logic CmdInit   = 1'b0;
    localparam logic CmdSample = 1'b1;

    localparam logic [11:0] PeriodReset    = 12'd109;
    localparam logic [31:0] PhaseStepReset = 32'd39403370;
    localparam logic [15:0] DampGainReset  = 16'd32627;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] mix_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mix_out;
        logic signed [23:0] note_sample;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    function automatic logic [16:0] harm_weight(input logic [HarmW-1:0] j);
        logic [16:0] w;
        unique case (j)
            5'd0: w = 17'd65536;  5'd1: w = 17'd26153;  5'd2: w = 17'd15034;
            5'd3: w = 17'd9951;   5'd4: w = 17'd12894;  5'd5: w = 17'd6143;
            5'd6: w = 17'd3989;   5'd7: w = 17'd9084;   5'd8: w = 17'd690;
            5'd9: w = 17'd4654;   5'd10: w = 17'd1963;  5'd11: w = 17'd3362;
            5'd12: w = 17'd3667;  5'd13: w = 17'd4339;  5'd14: w = 17'd660;
            5'd15: w = 17'd494;   5'd16: w = 17'd537;   5'd17: w = 17'd849;
            5'd18: w = 17'd480;   5'd19: w = 17'd407;   5'd20: w = 17'd335;
            5'd21: w = 17'd409;   5'd22: w = 17'd187;   5'd23: w = 17'd168;
            5'd24: w = 17'd0;     5'd25: w = 17'd108;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // Sine value in signed Q16, computed by a fixed-point Taylor series.
    function automatic logic signed [17:0] sine_value(input int k);
        logic [63:0] x, x2, t, s, q;
        logic        neg;
        x = (64'd6746518852 * 64'(k)) / 64'(SineDepth);
        neg = 1'b0;
        if (x >= 64'd3373259426)
        begin
            x = x - 64'd3373259426;
            neg = 1'b1;
        end
        if (x > 64'd1686629713)
            x = (x > 64'd3373259426) ? 64'd0 : 64'd3373259426 - x;
        x2 = (x * x) >> 30;
        t = 64'd1073741824 - x2 / 64'd110;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        q = (s + 64'd8192) >> 14;
        return neg ? -$signed(18'(q)) : $signed(18'(q));
    endfunction

endpackage
`default_nettype wire

[rtl/hpss_ring_ram.sv]
// Ring memory of one period, synchronous read: the data appear in the cycle after the address.
`default_nettype none
module hpss_ring_ram
(
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [hpss_pkg::AddrW-1:0]  waddr,
    input  wire logic [hpss_pkg::RingW-1:0]  wdata,
    input  wire logic [hpss_pkg::AddrW-1:0]  raddr,
    output      logic [hpss_pkg::RingW-1:0]  rdata
);
    import hpss_pkg::*;

    logic [RingW-1:0] mem [MaxPeriod];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/hpss_sine_rom.sv]
// Registered sine table lookup.
`default_nettype none
module hpss_sine_rom
(
    input  wire logic                        clk,
    input  wire logic [hpss_pkg::SineW-1:0]  addr,
    output      logic signed [17:0]          data
);
    import hpss_pkg::*;

    logic signed [17:0] rom [SineDepth];

    always_comb
    begin
        for (int k = 0; k < SineDepth; k++)
            rom[k] = sine_value(k);
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end
endmodule
`default_nettype wire

[rtl/harmonic_plucked_string_synth_top.sv]
// Top level of the plucked-string synth: control, clearing pass, ring update and harmonic build.
//
//  channel   direction  handshake        payload
//  in        input      in_valid/stall   in_item_t (cmd, mix_in)
//  out       output     out_valid/stall  out_item_t (mix_out, note_sample)
//  cfg       input      cfg_valid/ready  cfg_item_t (index, data)
//
// A sample item reads the current and next entry through one memory port in IDLE, RD1 and
// RD2, then damps, writes back and registers the result in CALC; it is valid after CALC.
// An init item builds the ring entry by entry: one harmonic per cycle in HARM, a wait in
// DRAIN for the weight multiplier to empty, and a write of the entry in WRITE.
// After reset a clearing pass zeros all MaxPeriod ring entries before the first item.
// The input is stalled while an item is in work and while a result waits in the output
// register, so a new item is taken only once the last one is through.
`default_nettype none
module harmonic_plucked_string_synth_top
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire hpss_pkg::in_item_t    in_item,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      hpss_pkg::out_item_t   out_item,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire hpss_pkg::cfg_item_t   cfg_item
);
    import hpss_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_RD2   = 8'b0000_1000,
        S_CALC  = 8'b0001_0000,
        S_HARM  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_WRITE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] period_reg;
    logic [31:0] phase_step_reg;
    logic [15:0] damp_gain_reg;
    logic [AddrW-1:0] pos_reg, pos_next;
    logic [AddrW-1:0] cur_reg, nxt_reg;
    logic [AddrW:0]   idx_reg, idx_next;
    logic [HarmW-1:0] harm_reg, harm_next;
    logic [31:0] base_phase_reg, base_phase_next;
    logic [31:0] harm_phase_reg, harm_phase_next;
    logic [HarmW-1:0] harm_d1_reg;
    logic        acc_v1_reg, acc_v2_reg;
    logic signed [47:0] acc_reg;
    logic signed [34:0] prod_reg;
    logic signed [RingW-1:0] cur_val_reg;
    logic signed [31:0] mix_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic [AddrW:0] eff_p;
    always_comb
    begin
        if (period_reg < 12'd2)
            eff_p = (AddrW+1)'(2);
        else if (32'(period_reg) > 32'(MaxPeriod))
            eff_p = (AddrW+1)'(MaxPeriod);
        else
            eff_p = (AddrW+1)'(period_reg);
    end

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [RingW-1:0] ram_wdata, ram_rdata;
    logic signed [17:0] sine_data;

    hpss_ring_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    hpss_sine_rom u_rom (
        .clk(clk), .addr(harm_phase_reg[31 -: SineW]), .data(sine_data)
    );

    logic accept;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    logic [AddrW:0] cur_w, nxt_w;
    always_comb
    begin
        cur_w = ({1'b0, pos_reg} >= eff_p) ? '0 : {1'b0, pos_reg};
        nxt_w = (cur_w + 1'b1 >= eff_p) ? '0 : cur_w + 1'b1;
    end

    logic signed [24:0] pair_sum;
    logic signed [41:0] damp_prod;
    logic [41:0] damp_mag;
    logic [25:0] damp_q;
    logic signed [26:0] damp_r;
    logic signed [RingW-1:0] note_val;
    logic signed [32:0] mix_sum;
    logic signed [31:0] mix_sat;
    always_comb
    begin
        pair_sum  = 25'(cur_val_reg) + 25'($signed(ram_rdata));
        damp_prod = 42'(pair_sum) * $signed({1'b0, damp_gain_reg});
        damp_mag  = damp_prod[41] ? 42'(-damp_prod) : damp_prod;
        damp_q    = 26'((damp_mag + 42'd32768) >> 16);
        damp_r    = damp_prod[41] ? -$signed({1'b0, damp_q}) : $signed({1'b0, damp_q});
        if (damp_r > 27'sd8388607)
            note_val = 24'sd8388607;
        else if (damp_r < -27'sd8388608)
            note_val = -24'sd8388608;
        else
            note_val = 24'(damp_r);
        mix_sum = 33'(mix_reg) + 33'(note_val);
        if (mix_sum > 33'sd2147483647)
            mix_sat = 32'sh7fffffff;
        else if (mix_sum < -33'sd2147483648)
            mix_sat = 32'sh80000000;
        else
            mix_sat = 32'(mix_sum);
    end

    logic [47:0] acc_mag;
    logic [33:0] acc_q;
    logic signed [34:0] acc_r;
    logic signed [RingW-1:0] ring_val;
    always_comb
    begin
        acc_mag = acc_reg[47] ? 48'(-acc_reg) : acc_reg;
        acc_q   = 34'((acc_mag + 48'd8192) >> 14);
        acc_r   = acc_reg[47] ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
        if (acc_r > 35'sd8388607)
            ring_val = 24'sd8388607;
        else if (acc_r < -35'sd8388608)
            ring_val = -24'sd8388608;
        else
            ring_val = 24'(acc_r);
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        harm_next       = harm_reg;
        base_phase_next = base_phase_reg;
        harm_phase_next = harm_phase_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AddrW-1:0];
        ram_wdata       = '0;
        ram_raddr       = cur_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == (AddrW+1)'(MaxPeriod - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                ram_raddr = cur_w[AddrW-1:0];
                if (accept)
                begin
                    if (in_item.cmd == CmdSample)
                        state_next = S_RD1;
                    else
                    begin
                        state_next      = S_HARM;
                        idx_next        = '0;
                        harm_next       = '0;
                        base_phase_next = '0;
                        harm_phase_next = '0;
                    end
                end
            end
            S_RD1:
            begin
                ram_raddr  = nxt_reg;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ram_raddr  = nxt_reg;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = note_val;
                pos_next   = nxt_reg;
                state_next = S_IDLE;
            end
            S_HARM:
            begin
                harm_phase_next = harm_phase_reg + base_phase_reg;
                harm_next       = harm_reg + 1'b1;
                if (harm_reg == HarmW'(HarmonicCount - 1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!acc_v1_reg && !acc_v2_reg)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we          = 1'b1;
                ram_wdata       = ring_val;
                idx_next        = idx_reg + 1'b1;
                base_phase_next = base_phase_reg + phase_step_reg;
                harm_phase_next = '0;
                harm_next       = '0;
                if (idx_reg + 1'b1 >= eff_p)
                begin
                    state_next = S_IDLE;
                    pos_next   = '0;
                end
                else
                    state_next = S_HARM;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            period_reg     <= PeriodReset;
            phase_step_reg <= PhaseStepReset;
            damp_gain_reg  <= DampGainReset;
            pos_reg        <= '0;
            idx_reg        <= '0;
            harm_reg       <= '0;
            acc_v1_reg     <= 1'b0;
            acc_v2_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            harm_reg  <= harm_next;
            acc_v1_reg <= (state_reg == S_HARM);
            acc_v2_reg <= acc_v1_reg;
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_item.index)
                    RegPeriod:    period_reg     <= cfg_item.data[11:0];
                    RegPhaseStep: phase_step_reg <= cfg_item.data;
                    RegDampGain:  damp_gain_reg  <= cfg_item.data[15:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if ((state_reg == S_CALC) ||
                (state_reg == S_WRITE && idx_reg + 1'b1 >= eff_p))
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        base_phase_reg <= base_phase_next;
        if (state_reg == S_IDLE || state_reg == S_WRITE)
            harm_phase_reg <= base_phase_next;
        else
            harm_phase_reg <= harm_phase_next;
        harm_d1_reg <= harm_reg;
        if (acc_v1_reg)
            prod_reg <= 35'($signed({1'b0, harm_weight(harm_d1_reg)})) * 35'(sine_data);
        if (state_reg == S_IDLE || state_reg == S_WRITE)
            acc_reg <= '0;
        else if (acc_v2_reg)
            acc_reg <= acc_reg + 48'(prod_reg);
        if (state_reg == S_IDLE && accept)
        begin
            cur_reg <= cur_w[AddrW-1:0];
            nxt_reg <= nxt_w[AddrW-1:0];
            mix_reg <= in_item.mix_in;
        end
        if (state_reg == S_RD1)
            cur_val_reg <= $signed(ram_rdata);
        if (state_reg == S_CALC)
        begin
            out_reg.mix_out     <= mix_sat;
            out_reg.note_sample <= note_val;
        end
        else if (state_reg == S_WRITE && idx_reg + 1'b1 >= eff_p)
        begin
            out_reg.mix_out     <= mix_reg;
            out_reg.note_sample <= '0;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("item accepted while busy");
    a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |=> out_valid)
        else $error("sample result missing");
    a_calc_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> ram_we)
        else $error("damped sample not written back");
`endif
endmodule
`default_nettype wire
